@@ design/assert_macros.svh @@
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition in the following cycle
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/ist_pkg.sv @@
// package of the integer set table: sizes, operation codes and memory request type
package ist_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int KIND_W   = 2;
  localparam int LIMIT_W  = 7;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
  } mem_req_t;

endpackage

@@ design/ist_in_if.sv @@
// input channel of the integer set table
interface ist_in_if import ist_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [KIND_W-1:0] kind;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

@@ design/ist_out_if.sv @@
// result channel of the integer set table
interface ist_out_if import ist_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [POS_W-1:0]   position;
  logic               changed;
  logic [COUNT_W-1:0] element_count;

  modport source (output valid, output found, output position, output changed,
                  output element_count, input ready);
  modport sink (input valid, input found, input position, input changed,
                input element_count, output ready);
endinterface

@@ design/ist_store.sv @@
// element store: one write port, one registered read port
module ist_store import ist_pkg::*; (
  input  logic             clk,
  input  mem_req_t         req,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/ist_seq.sv @@
// sequencer: linear search with one shared comparator, update and result register
module ist_seq import ist_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  ist_in_if.sink             in_ch,
  ist_out_if.source          out_ch,
  output mem_req_t           req,
  input  logic [VAL_W-1:0]   rdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MOVE = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0]         state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [VAL_W-1:0]   value_r, value_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic               found_r, found_nxt;
  logic               chg_r, chg_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  logic [POS_W-1:0]   out_pos_r;
  logic               out_chg_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               load;
  logic               match;
  logic               last;
  logic               room;

  assign match = (rdata == value_r);
  assign last  = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);
  assign room  = (32'(count_r) < 32'(limit_r)) && (32'(count_r) < CAPACITY);
  assign load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    value_nxt    = value_r;
    scan_idx_nxt = scan_idx_r;
    hit_idx_nxt  = hit_idx_r;
    found_nxt    = found_r;
    chg_nxt      = chg_r;
    count_nxt    = count_r;
    limit_nxt    = cfg_we ? cfg_wdata : limit_r;
    req          = '0;
    req.wr_data  = value_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt     = in_ch.kind;
          value_nxt    = VAL_W'(in_ch.value);
          scan_idx_nxt = '0;
          hit_idx_nxt  = '0;
          found_nxt    = 1'b0;
          chg_nxt      = 1'b0;
          if (count_r == '0) begin
            state_nxt = S_DONE;
            if (in_ch.kind == KIND_ADD && room) begin
              req.wr_en   = 1'b1;
              req.wr_addr = '0;
              req.wr_data = VAL_W'(in_ch.value);
              count_nxt   = CNT_W'(1);
              chg_nxt     = 1'b1;
            end
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = '0;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match || last) begin
          found_nxt   = match;
          hit_idx_nxt = match ? scan_idx_r : '0;
          state_nxt   = S_DONE;
          unique case (kind_r)
            KIND_ADD: begin
              if (!match && room) begin
                req.wr_en   = 1'b1;
                req.wr_addr = IDX_W'(count_r);
                count_nxt   = count_r + CNT_W'(1);
                chg_nxt     = 1'b1;
              end
            end
            KIND_REMOVE: begin
              if (match) begin
                req.rd_en   = 1'b1;
                req.rd_addr = IDX_W'(count_r - CNT_W'(1));
                count_nxt   = count_r - CNT_W'(1);
                chg_nxt     = 1'b1;
                state_nxt   = S_MOVE;
              end
            end
            default: begin
            end
          endcase
        end else begin
          req.rd_en    = 1'b1;
          req.rd_addr  = scan_idx_r + IDX_W'(1);
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      S_MOVE: begin
        // last live entry fills the freed slot
        req.wr_en   = 1'b1;
        req.wr_addr = hit_idx_r;
        req.wr_data = rdata;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    value_r    <= value_nxt;
    scan_idx_r <= scan_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    found_r    <= found_nxt;
    chg_r      <= chg_nxt;
    if (load) begin
      out_found_r <= found_r;
      out_pos_r   <= POS_W'(hit_idx_r);
      out_chg_r   <= chg_r;
      out_count_r <= COUNT_W'(count_r);
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.position      = out_pos_r;
  assign out_ch.changed       = out_chg_r;
  assign out_ch.element_count = out_count_r;

endmodule

@@ design/integer_set_table.sv @@
// integer set table: top level joining the sequencer and the element store
//
// in_ch carries kind (query, add, remove) and a signed 32-bit value; each
// transfer on in_ch gives exactly one transfer on out_ch with found, position,
// changed and the element count after the operation.
// cfg_we with cfg_wdata sets the capacity limit (reset 64); write it only
// while no operation is in progress.
// an item scans k live entries, one compare per cycle on the store's
// registered read port, k being the first match position plus one or the count.
// after the scan a query or add goes to the result state; a remove that hits
// first passes a move state that copies the last entry; an empty set skips
// the scan. in_ch.ready is low while busy.
// the result sits in an output register; the next item is taken while it waits,
// and a stalled out_ch holds the following result in the sequencer until free.
// reset empties the set at once and restores the limit; the store contents
// are left as they are and only live entries are ever read.
module integer_set_table import ist_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  ist_in_if.sink             in_ch,
  ist_out_if.source          out_ch
);

  mem_req_t         req;
  logic [VAL_W-1:0] rdata;

  ist_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .req       (req),
    .rdata     (rdata)
  );

  ist_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule

@@ design/ist_checker.sv @@
// port checker of the integer set table and its bind
`include "assert_macros.svh"

module ist_checker import ist_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_found,
  input logic [POS_W-1:0]   out_position,
  input logic               out_changed,
  input logic [COUNT_W-1:0] out_element_count
);

  `ASSERT_NXT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_IMP(a_count_bound, clk, rst_n, out_valid, out_element_count <= COUNT_W'(CAPACITY))
  `ASSERT_IMP(a_miss_pos_zero, clk, rst_n, out_valid && !out_found, out_position == '0)
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_position) && $stable(out_changed) && $stable(out_element_count))

endmodule

bind integer_set_table ist_checker u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_found         (out_ch.found),
  .out_position      (out_ch.position),
  .out_changed       (out_ch.changed),
  .out_element_count (out_ch.element_count)
);
